// ===== hdl/idl_pkg.sv =====
// shared types, codes and constants of the id list engine
package idl_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int ID_W = 16;
  localparam int REQ_W = 3;
  localparam int POS_W = 8;
  localparam int RND_W = 32;
  localparam int CNT_OUT_W = 9;
  localparam int ST_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RM_VALUE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RM_RANGE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PACK     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RM_POS   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RAND     = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic decode;
    logic append;
    logic sweep_init;
    logic sweep;
    logic sweep_end;
    logic mv_rd;
    logic mv_wr;
    logic div_start;
    logic sel_rd;
    logic sel_cap;
    logic emit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             err;
    logic             sweep_done;
    logic             div_done;
  } sts_t;

endpackage

// ===== hdl/idl_ram.sv =====
// generic single write, single read ram with registered read data
module idl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/idl_mod.sv =====
// iterative remainder unit, one dividend bit per cycle
module idl_mod #(
  parameter int DW = 32,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);

  localparam int SW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [DW-1:0] dvd_r;
  logic [VW-1:0] dvs_r;
  logic [VW-1:0] rem_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          take;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign take  = trial >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(DW);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= take ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/idl_dp.sv =====
// datapath: request latch, list store, count, scan pointers, result registers
module idl_dp #(
  parameter int CAPACITY = idl_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  idl_pkg::cmd_t                 cmd,
  input  logic [idl_pkg::REQ_W-1:0]     in_req_type,
  input  logic [idl_pkg::ID_W-1:0]      in_id_value,
  input  logic [idl_pkg::ID_W-1:0]      in_range_high,
  input  logic [idl_pkg::POS_W-1:0]     in_position,
  input  logic [idl_pkg::RND_W-1:0]     in_random_word,
  output idl_pkg::sts_t                 sts,
  output logic                          out_strobe,
  output logic [idl_pkg::ID_W-1:0]      out_id_out,
  output logic [idl_pkg::CNT_OUT_W-1:0] out_entry_count,
  output logic [idl_pkg::ST_W-1:0]      out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + idl_pkg::POS_W;

  // latched request
  logic [idl_pkg::REQ_W-1:0] req_r;
  logic [idl_pkg::ID_W-1:0]  idv_r;
  logic [idl_pkg::ID_W-1:0]  hi_r;
  logic [idl_pkg::POS_W-1:0] pos_r;
  logic [idl_pkg::RND_W-1:0] rnd_r;

  // list state and scan pointers
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] wr_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_addr_r;

  // result
  logic [idl_pkg::ST_W-1:0]      status_r;
  logic [idl_pkg::ID_W-1:0]      id_r;
  logic                          out_strobe_r;
  logic [idl_pkg::ID_W-1:0]      out_id_r;
  logic [idl_pkg::CNT_OUT_W-1:0] out_cnt_r;
  logic [idl_pkg::ST_W-1:0]      out_status_r;

  // ram ports
  logic                     ram_wr_en;
  logic [AW-1:0]            ram_wr_addr;
  logic [idl_pkg::ID_W-1:0] ram_wr_data;
  logic                     ram_rd_en;
  logic [AW-1:0]            ram_rd_addr;
  logic [idl_pkg::ID_W-1:0] ram_rd_data;

  // misc
  logic [PW-1:0]               pos_w;
  logic [PW-1:0]               cnt_w;
  logic [AW+idl_pkg::POS_W-1:0] pos_a;
  logic [CW+idl_pkg::CNT_OUT_W-1:0] cnt_o;
  logic [CW-1:0]               cnt_m1;
  logic [CW-1:0]               rem;
  logic                        div_done;
  logic                        cnt_zero;
  logic                        bad_pos;
  logic                        scan_more;
  logic                        is_pack;
  logic                        hit;
  logic                        nonzero;
  logic [idl_pkg::ID_W-1:0]    hi_bound;
  logic [idl_pkg::ST_W-1:0]    err_code;

  assign pos_w    = PW'(pos_r);
  assign cnt_w    = PW'(count_r);
  assign pos_a    = (AW + idl_pkg::POS_W)'(pos_r);
  assign cnt_o    = (CW + idl_pkg::CNT_OUT_W)'(count_r);
  assign cnt_m1   = count_r - 1'b1;
  assign cnt_zero = (count_r == '0);
  assign bad_pos  = (pos_w >= cnt_w) || (pos_w >= PW'(CAPACITY));
  assign scan_more = (idx_r < count_r);
  assign is_pack  = (req_r == idl_pkg::REQ_PACK);

  // range compare on the returned entry
  assign hi_bound = (req_r == idl_pkg::REQ_RM_VALUE) ? idv_r : hi_r;
  assign hit      = (ram_rd_data >= idv_r) && (ram_rd_data <= hi_bound);
  assign nonzero  = (ram_rd_data != '0);

  // error check on the latched request
  always_comb begin
    err_code = idl_pkg::ST_OK;
    case (req_r)
      idl_pkg::REQ_APPEND: begin
        if (count_r >= CW'(CAPACITY)) err_code = idl_pkg::ST_FULL;
      end
      idl_pkg::REQ_RM_POS: begin
        if (cnt_zero)     err_code = idl_pkg::ST_EMPTY;
        else if (bad_pos) err_code = idl_pkg::ST_BADPOS;
      end
      idl_pkg::REQ_RAND: begin
        if (cnt_zero) err_code = idl_pkg::ST_EMPTY;
      end
      default: err_code = idl_pkg::ST_OK;
    endcase
  end

  assign sts.req        = req_r;
  assign sts.err        = (err_code != idl_pkg::ST_OK);
  assign sts.sweep_done = !scan_more && !rd_vld_r;
  assign sts.div_done   = div_done;

  // ram port steering
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[AW-1:0];
    ram_wr_data = idv_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r[AW-1:0];
    if (cmd.append) begin
      ram_wr_en = 1'b1;
    end
    if (cmd.sweep && rd_vld_r) begin
      if (is_pack) begin
        ram_wr_en   = nonzero;
        ram_wr_addr = wr_r[AW-1:0];
        ram_wr_data = ram_rd_data;
      end else begin
        ram_wr_en   = hit;
        ram_wr_addr = rd_addr_r;
        ram_wr_data = '0;
      end
    end
    if (cmd.mv_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = pos_a[AW-1:0];
      ram_wr_data = ram_rd_data;
    end
    if (cmd.sweep && scan_more) begin
      ram_rd_en = 1'b1;
    end
    if (cmd.mv_rd) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = cnt_m1[AW-1:0];
    end
    if (cmd.sel_rd) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = rem[AW-1:0];
    end
  end

  idl_ram #(
    .WIDTH (idl_pkg::ID_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  idl_mod #(
    .DW (idl_pkg::RND_W),
    .VW (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rnd_r),
    .divisor  (count_r),
    .done     (div_done),
    .rem      (rem)
  );

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req_type;
      idv_r <= in_id_value;
      hi_r  <= in_range_high;
      pos_r <= in_position;
      rnd_r <= in_random_word;
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.append)                count_nxt = count_r + 1'b1;
    if (cmd.sweep_end && is_pack)  count_nxt = wr_r;
    if (cmd.mv_wr)                 count_nxt = cnt_m1;
  end

  // control registers: count, scan pipeline, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= cmd.emit;
      if (cmd.sweep_init) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.sweep) begin
        rd_vld_r <= scan_more;
      end
    end
  end

  // scan pointers
  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      idx_r <= '0;
      wr_r  <= '0;
    end else if (cmd.sweep) begin
      rd_addr_r <= idx_r[AW-1:0];
      if (scan_more) idx_r <= idx_r + 1'b1;
      if (rd_vld_r && is_pack && nonzero) wr_r <= wr_r + 1'b1;
    end
  end

  // status and selected id
  always_ff @(posedge clk) begin
    if (cmd.latch)   id_r <= '0;
    if (cmd.sel_cap) id_r <= ram_rd_data;
    if (cmd.decode)  status_r <= err_code;
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_id_r     <= id_r;
      out_cnt_r    <= cnt_o[idl_pkg::CNT_OUT_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_id_out      = out_id_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_status_r;

endmodule

// ===== hdl/idl_ctrl.sv =====
// controller state machine: sequences one request through the datapath
module idl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  idl_pkg::sts_t sts,
  output idl_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SWEEP   = 3'd2;
  localparam logic [2:0] S_MOVE    = 3'd3;
  localparam logic [2:0] S_DIV     = 3'd4;
  localparam logic [2:0] S_SEL_CAP = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_FINISH;
        if (!sts.err) begin
          case (sts.req)
            idl_pkg::REQ_APPEND: begin
              cmd.append = 1'b1;
            end
            idl_pkg::REQ_RM_VALUE, idl_pkg::REQ_RM_RANGE, idl_pkg::REQ_PACK: begin
              cmd.sweep_init = 1'b1;
              state_nxt      = S_SWEEP;
            end
            idl_pkg::REQ_RM_POS: begin
              cmd.mv_rd = 1'b1;
              state_nxt = S_MOVE;
            end
            idl_pkg::REQ_RAND: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          cmd.sweep_end = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_MOVE: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_FINISH;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.sel_rd = 1'b1;
          state_nxt  = S_SEL_CAP;
        end
      end
      S_SEL_CAP: begin
        cmd.sel_cap = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/id_list_remove_compact_engine_core.sv =====
// top level of the id list engine: controller, datapath and checks
//
// Keeps an unordered list of up to CAPACITY 16-bit ids and serves one
// request at a time: append, remove value, remove range, pack, remove at
// position (last entry swapped into the slot) and random select.
// A request beat is taken at a rising edge where start is high and busy is
// low; busy then stays high until the request is done.
// Each request gives one result beat: out_strobe is high for one cycle with
// out_id_out, out_entry_count and out_status valid. The receiver cannot
// stall; the result is taken in that cycle, and start may be raised in it.
// Steps from accept to result strobe, by controller state:
//   append, errors, unused codes: decode, finish (remove at position: move too)
//   remove value, remove range, pack: decode, sweep over the list, finish;
//   one list entry per cycle through the single read port of the store
//   random select: decode, the bit-serial remainder unit, select, finish
// A new request can be taken in the cycle the strobe is shown.
// Reset (rst_n low, synchronous) empties the list and idles the block; the
// store itself is not cleared, only entries below the count are ever read.
module id_list_remove_compact_engine_core #(
  parameter int CAPACITY = idl_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [idl_pkg::REQ_W-1:0]     in_req_type,
  input  logic [idl_pkg::ID_W-1:0]      in_id_value,
  input  logic [idl_pkg::ID_W-1:0]      in_range_high,
  input  logic [idl_pkg::POS_W-1:0]     in_position,
  input  logic [idl_pkg::RND_W-1:0]     in_random_word,
  output logic                          out_strobe,
  output logic [idl_pkg::ID_W-1:0]      out_id_out,
  output logic [idl_pkg::CNT_OUT_W-1:0] out_entry_count,
  output logic [idl_pkg::ST_W-1:0]      out_status
);

  idl_pkg::cmd_t cmd;
  idl_pkg::sts_t sts;

  idl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  idl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_id_value     (in_id_value),
    .in_range_high   (in_range_high),
    .in_position     (in_position),
    .in_random_word  (in_random_word),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_id_out      (out_id_out),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  // a request ends with exactly one result beat
  a_fell_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result beat");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in a row");

  // error results carry consistent fields
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == idl_pkg::ST_FULL)
      |-> out_entry_count == idl_pkg::CNT_OUT_W'(CAPACITY))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == idl_pkg::ST_EMPTY) |-> out_entry_count == '0)
    else $error("empty status with nonzero count");

  a_err_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != idl_pkg::ST_OK) |-> out_id_out == '0)
    else $error("error result with nonzero id");

endmodule
